// ===== hw/rtl/feistel_index_permuter_defines.svh =====
// Assertion macros used by the RTL.
`ifndef FEISTEL_INDEX_PERMUTER_DEFINES_SVH
`define FEISTEL_INDEX_PERMUTER_DEFINES_SVH

`ifndef SYNTHESIS

`define FIP_ASSERT_IMPL(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed");

`define FIP_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define FIP_ASSERT_IMPL(name, clk, rstn, pre, post)

`define FIP_ASSERT_NEXT(name, clk, rstn, pre, post)

`endif

`endif

// ===== hw/rtl/fip_pkg.sv =====
`default_nettype none

package fip_pkg;

    localparam int IDX_W          = 21;
    localparam int LEFT_W         = 11;
    localparam int RB_CFG_W       = 4;
    localparam int MIN_RWIDTH     = 5;
    localparam int WORD_W         = 32;
    localparam int RSEL_W         = 3;
    localparam int SLOT_W         = 10;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;

    // left + (word >> right width) fits in this many bits
    localparam int SUM_W      = WORD_W - MIN_RWIDTH + 1;
    localparam int DIGIT_W    = 7;
    localparam int NUM_DIGITS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RWIDTH   = 1'b0,
        CFG_LEFT_MOD = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_PERMUTE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_USE,
        ST_MOD,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/feistel_index_permuter.sv =====
// Load request: one per cycle while idle, no result.
// Permute request: odd rounds run ISSUE then USE, even rounds run ISSUE, USE and MOD for the
// table read and the 7-bit-per-cycle modulo; the result comes from OUT, and no new request is
// taken until OUT has issued it. Out-of-range request: goes from IDLE straight to OUT.
// Reset (aresetn low, synchronous) clears control and sets right width 5, left_mod 32;
// table memory is not cleared.
`default_nettype none
`include "feistel_index_permuter_defines.svh"

module feistel_index_permuter
    import fip_pkg::*;
#(
    parameter int NUM_ROUNDS = 5,
    parameter int MAX_RWIDTH = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [RSEL_W-1:0]     s_round_select,
    input  logic [SLOT_W-1:0]     s_table_slot,
    input  logic [WORD_W-1:0]     s_table_word,
    input  logic [IDX_W-1:0]      s_source_index,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IDX_W-1:0]      m_permuted_index,
    output logic                  m_range_error
);

    localparam int SLOTS  = 1 << MAX_RWIDTH;
    localparam int DEPTH  = NUM_ROUNDS * SLOTS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RND_W  = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
    localparam int RB_W   = $clog2(MAX_RWIDTH + 1);
    localparam int SIZE_W = (LEFT_W + MAX_RWIDTH > IDX_W) ?
                            (LEFT_W + MAX_RWIDTH) : IDX_W;
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(NUM_ROUNDS - 1);

    function automatic logic [LEFT_W:0] mod_digits(
        input logic [LEFT_W:0]   rem_in,
        input logic [DIGIT_W-1:0] bits,
        input logic [LEFT_W-1:0] m
    );
        logic [LEFT_W:0] r;
        r = rem_in;
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            r = {r[LEFT_W-1:0], bits[i]};
            if (r >= {1'b0, m}) begin
                r = r - {1'b0, m};
            end
        end
        return r;
    endfunction

    state_t                    state_reg, state_next;
    logic [RB_CFG_W-1:0]       rwidth_reg, rwidth_next;
    logic [LEFT_W-1:0]         left_mod_reg, left_mod_next;
    logic [RND_W-1:0]          round_reg, round_next;
    logic [LEFT_W-1:0]         left_reg, left_next;
    logic [MAX_RWIDTH-1:0]     right_reg, right_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [DIG_CNT_W-1:0]      digit_reg, digit_next;
    logic [LEFT_W:0]           rem_reg, rem_next;
    logic                      flag_reg, flag_next;
    logic                      m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]          out_index_reg, out_index_next;
    logic                      out_err_reg, out_err_next;

    logic [RB_W-1:0]           rb;
    logic [MAX_RWIDTH-1:0]     rmask;
    logic [SIZE_W-1:0]         size;
    logic [SIZE_W-1:0]         result;
    logic [MAX_RWIDTH-1:0]     slot_sel;
    logic [WORD_W-1:0]         word_shr;
    logic                      in_acc;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             ram_raddr;
    logic [WORD_W-1:0]         ram_rdata;

    fip_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_tables (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_table_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (rwidth_reg < RB_CFG_W'(MIN_RWIDTH)) begin
            rb = RB_W'(MIN_RWIDTH);
        end else if (32'(rwidth_reg) > MAX_RWIDTH) begin
            rb = RB_W'(MAX_RWIDTH);
        end else begin
            rb = RB_W'(rwidth_reg);
        end
    end

    assign rmask    = ~({MAX_RWIDTH{1'b1}} << rb);
    assign size     = SIZE_W'(left_mod_reg) << rb;
    assign result   = (SIZE_W'(left_reg) << rb) | SIZE_W'(right_reg);
    assign slot_sel = round_reg[0] ? (MAX_RWIDTH'(left_reg) & rmask) : right_reg;
    assign word_shr = ram_rdata >> rb;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;

    assign ram_we    = in_acc && (cmd_t'(s_command) == CMD_LOAD)
                       && (32'(s_round_select) < NUM_ROUNDS) && (32'(s_table_slot) < SLOTS);
    assign ram_waddr = AW'({s_round_select, MAX_RWIDTH'(s_table_slot)});
    assign ram_raddr = AW'({round_reg, slot_sel});

    always_comb begin
        rwidth_next   = rwidth_reg;
        left_mod_next = left_mod_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_RWIDTH:   rwidth_next   = cfg_data[RB_CFG_W-1:0];
                CFG_LEFT_MOD: left_mod_next = cfg_data[LEFT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        sum_next       = sum_reg;
        digit_next     = digit_reg;
        rem_next       = rem_reg;
        flag_next      = flag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_index_next = out_index_reg;
        out_err_next   = out_err_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (cmd_t'(s_command) == CMD_PERMUTE)) begin
                    right_next = MAX_RWIDTH'(s_source_index) & rmask;
                    left_next  = LEFT_W'(s_source_index >> rb);
                    round_next = '0;
                    if ((left_mod_reg == '0) || (SIZE_W'(s_source_index) >= size)) begin
                        flag_next  = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        flag_next  = 1'b0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                state_next = ST_USE;
            end
            ST_USE: begin
                if (round_reg[0]) begin
                    right_next = right_reg ^ (ram_rdata[MAX_RWIDTH-1:0] & rmask);
                    if (round_reg == RND_W'(NUM_ROUNDS - 1)) begin
                        state_next = ST_OUT;
                    end else begin
                        round_next = round_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end else begin
                    sum_next   = SUM_W'(word_shr) + SUM_W'(left_reg);
                    rem_next   = '0;
                    digit_next = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                rem_next   = mod_digits(rem_reg, sum_reg[SUM_W-1 -: DIGIT_W], left_mod_reg);
                sum_next   = sum_reg << DIGIT_W;
                digit_next = digit_reg + 1'b1;
                if (digit_reg == DIG_CNT_W'(NUM_DIGITS - 1)) begin
                    left_next = rem_next[LEFT_W-1:0];
                    if (round_reg == RND_W'(NUM_ROUNDS - 1)) begin
                        state_next = ST_OUT;
                    end else begin
                        round_next = round_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (flag_reg || (result >= size) || (result > SIZE_W'(IDX_MAX))) begin
                        out_index_next = '0;
                        out_err_next   = 1'b1;
                    end else begin
                        out_index_next = IDX_W'(result);
                        out_err_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rwidth_reg   <= RB_CFG_W'(5);
            left_mod_reg <= LEFT_W'(32);
            m_valid_reg  <= 1'b0;
            flag_reg     <= 1'b0;
            round_reg    <= '0;
            digit_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            rwidth_reg   <= rwidth_next;
            left_mod_reg <= left_mod_next;
            m_valid_reg  <= m_valid_next;
            flag_reg     <= flag_next;
            round_reg    <= round_next;
            digit_reg    <= digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg      <= left_next;
        right_reg     <= right_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        out_index_reg <= out_index_next;
        out_err_reg   <= out_err_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_permuted_index = out_index_reg;
    assign m_range_error    = out_err_reg;

    `FIP_ASSERT_IMPL(a_we_idle, aclk, aresetn, ram_we, state_reg == ST_IDLE)
    `FIP_ASSERT_IMPL(a_round_range, aclk, aresetn, state_reg != ST_IDLE, round_reg <= LAST_RND)
    `FIP_ASSERT_IMPL(a_rem_ok, aclk, aresetn, state_reg == ST_MOD, (rem_reg < {1'b0, left_mod_reg}))
    `FIP_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_valid_reg && out_err_reg, out_index_reg == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/fip_ram.sv =====
`default_nettype none

module fip_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 5120,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
